>>> design/bcfb_pkg.sv
// ----------------------------------------------------------------------------
// bcfb_pkg
// Types and constants shared by the binary command frame builder modules.
// ----------------------------------------------------------------------------
package bcfb_pkg;

	// Item modes on the command channel
	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_PAYLOAD = 1'b1;

	// Frame sync bytes
	localparam logic [7:0] SYNC_FIRST  = 8'hF1;
	localparam logic [7:0] SYNC_SECOND = 8'hD9;

	// Command kinds in the queue between front and back
	typedef enum logic {
		KIND_START   = 1'b0,
		KIND_PAYLOAD = 1'b1
	} bcfb_kind_t;

	// Input item
	typedef struct packed {
		logic        mode;
		logic [7:0]  group_id;
		logic [7:0]  sub_id;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
	} bcfb_in_t;

	// Output item: one wire byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
	} bcfb_out_t;

	// Classified command, queued from front to back
	typedef struct packed {
		bcfb_kind_t  kind;
		logic        closes;    // frame ends with this command: append checksum
		logic [7:0]  group_id;
		logic [7:0]  sub_id;
		logic [15:0] length;
		logic [7:0]  data;
	} bcfb_cmd_t;

	// Queue status
	typedef struct packed {
		logic empty;
		logic full;
	} bcfb_qstat_t;

endpackage

>>> design/bcfb_queue.sv
// ----------------------------------------------------------------------------
// bcfb_queue
// Short command queue between the front and the back of the frame builder.
// ----------------------------------------------------------------------------
module bcfb_queue
	import bcfb_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bcfb_cmd_t                  push_cmd,
	input  logic                       pop,
	output bcfb_cmd_t                  head,
	output bcfb_qstat_t                stat,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

	bcfb_cmd_t         slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));
	assign level      = count_q;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/bcfb_front.sv
// ----------------------------------------------------------------------------
// bcfb_front
// Accepts input items, tracks the open frame and queues classified commands.
// ----------------------------------------------------------------------------
module bcfb_front
	import bcfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  bcfb_in_t    cmd_item,
	input  bcfb_qstat_t qstat,
	output logic        push,
	output bcfb_cmd_t   push_cmd
);

	logic [15:0] bytes_left_q;
	logic        frame_open_q;
	logic        accept;
	logic        is_start;

	assign cmd_ready = !qstat.full;
	assign accept    = cmd_valid && cmd_ready;
	assign is_start  = (cmd_item.mode == MODE_START);

	// Queue starts always, payload only while a frame is open; drop the rest
	assign push = accept && (is_start || frame_open_q);

	// Classify the item
	always_comb begin
		push_cmd.group_id = cmd_item.group_id;
		push_cmd.sub_id   = cmd_item.sub_id;
		push_cmd.length   = cmd_item.payload_length;
		push_cmd.data     = cmd_item.payload_byte;
		if (is_start) begin
			push_cmd.kind   = KIND_START;
			push_cmd.closes = (cmd_item.payload_length == 16'd0);
		end else begin
			push_cmd.kind   = KIND_PAYLOAD;
			push_cmd.closes = (bytes_left_q == 16'd1);
		end
	end

	// Track frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			frame_open_q <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				bytes_left_q <= cmd_item.payload_length;
				frame_open_q <= (cmd_item.payload_length != 16'd0);
			end else if (frame_open_q) begin
				bytes_left_q <= bytes_left_q - 16'd1;
				if (bytes_left_q == 16'd1) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> design/bcfb_back.sv
// ----------------------------------------------------------------------------
// bcfb_back
// Queued commands to Fletcher-summed wire bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module bcfb_back
	import bcfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bcfb_cmd_t   head,
	input  bcfb_qstat_t qstat,
	output logic        pop,
	output logic        frame_valid,
	input  logic        frame_ready,
	output bcfb_out_t   frame_item
);

	// Byte positions within a start command
	localparam logic [2:0] ST_SYNC0   = 3'd0;
	localparam logic [2:0] ST_SYNC1   = 3'd1;
	localparam logic [2:0] ST_GROUP   = 3'd2;
	localparam logic [2:0] ST_SUB     = 3'd3;
	localparam logic [2:0] ST_LEN_LO  = 3'd4;
	localparam logic [2:0] ST_LEN_HI  = 3'd5;
	localparam logic [2:0] ST_SUM_RUN = 3'd6;
	localparam logic [2:0] ST_SUM_WGT = 3'd7;
	// Byte positions within a payload command
	localparam logic [2:0] PL_DATA    = 3'd0;
	localparam logic [2:0] PL_SUM_RUN = 3'd1;
	localparam logic [2:0] PL_SUM_WGT = 3'd2;

	logic [2:0] step_q;
	logic [7:0] run_sum_q;
	logic [7:0] wgt_sum_q;
	logic       out_valid_q;
	bcfb_out_t  out_item_q;

	logic       emit;
	logic [7:0] next_byte;
	logic       summed;
	logic       clear_sums;
	logic [2:0] last_step;
	logic       is_last;
	logic [7:0] run_sum_n;

	assign frame_valid = out_valid_q;
	assign frame_item  = out_item_q;
	assign emit        = !qstat.empty && (!out_valid_q || frame_ready);
	assign is_last     = (step_q == last_step);
	assign pop         = emit && is_last;
	assign run_sum_n   = (clear_sums ? 8'd0 : run_sum_q) + next_byte;

	// Select the byte for the current step
	always_comb begin
		next_byte  = 8'd0;
		summed     = 1'b0;
		clear_sums = 1'b0;
		last_step  = 3'd0;
		case (head.kind)
			KIND_START: begin
				last_step = head.closes ? ST_SUM_WGT : ST_LEN_HI;
				case (step_q)
					ST_SYNC0:   begin next_byte = SYNC_FIRST; clear_sums = 1'b1; end
					ST_SYNC1:   next_byte = SYNC_SECOND;
					ST_GROUP:   begin next_byte = head.group_id;     summed = 1'b1; end
					ST_SUB:     begin next_byte = head.sub_id;       summed = 1'b1; end
					ST_LEN_LO:  begin next_byte = head.length[7:0];  summed = 1'b1; end
					ST_LEN_HI:  begin next_byte = head.length[15:8]; summed = 1'b1; end
					ST_SUM_RUN: next_byte = run_sum_q;
					ST_SUM_WGT: next_byte = wgt_sum_q;
					default:    next_byte = 8'd0;
				endcase
			end
			KIND_PAYLOAD: begin
				last_step = head.closes ? PL_SUM_WGT : PL_DATA;
				case (step_q)
					PL_DATA:    begin next_byte = head.data; summed = 1'b1; end
					PL_SUM_RUN: next_byte = run_sum_q;
					PL_SUM_WGT: next_byte = wgt_sum_q;
					default:    next_byte = 8'd0;
				endcase
			end
			default: last_step = 3'd0;
		endcase
	end

	// Advance step and sums, load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			run_sum_q   <= '0;
			wgt_sum_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				step_q      <= is_last ? 3'd0 : step_q + 3'd1;
				if (clear_sums) begin
					run_sum_q <= '0;
					wgt_sum_q <= '0;
				end else if (summed) begin
					run_sum_q <= run_sum_n;
					wgt_sum_q <= wgt_sum_q + run_sum_n;
				end
			end else if (frame_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q.out_byte  <= next_byte;
			out_item_q.run_last  <= is_last;
			out_item_q.frame_end <= is_last && head.closes;
		end
	end

endmodule

>>> design/binary_command_frame_builder_top.sv
// ----------------------------------------------------------------------------
// binary_command_frame_builder_top
// Builds sync-prefixed binary command frames with an 8-bit Fletcher checksum.
// ----------------------------------------------------------------------------
// A start item yields F1 D9, group, sub and the length low byte first (6 bytes),
// plus the two checksum bytes when the length is zero (8 bytes). A payload item
// of an open frame yields its byte, and the two checksum bytes after the last
// one (1 or 3 bytes); a payload item with no frame open is dropped. The back
// end emits one byte per cycle from a single output register while not stalled
// by frame_ready; an item holds the back end until all its bytes are out, so
// non-closing payload items stream at one item per cycle. The front end takes a
// new item every cycle while the command queue (QUEUE_DEPTH entries) has room.
module binary_command_frame_builder_top
	import bcfb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  bcfb_in_t  cmd_item,
	output logic      frame_valid,
	input  logic      frame_ready,
	output bcfb_out_t frame_item
);

	logic                             push;
	bcfb_cmd_t                        push_cmd;
	logic                             pop;
	bcfb_cmd_t                        head;
	bcfb_qstat_t                      qstat;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

	bcfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.qstat     (qstat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	bcfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (qstat),
		.level    (level)
	);

	bcfb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_item  (frame_item)
	);

`ifndef SYNTHESIS
	// The closing checksum byte is always the last byte of its item
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_item.frame_end |-> frame_item.run_last)
		else $error("frame_end without run_last");

	// The queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("command queue overflow");

	// A pop only happens on a nonempty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty && level != '0)
		else $error("pop from empty command queue");
`endif

endmodule

>>> tb/binary_command_frame_builder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_command_frame_builder_top_test
// Drives start and payload items into the frame builder and checks every wire
// byte against a cycle-free predictor of the frame and Fletcher checksum.
// ----------------------------------------------------------------------------
// A short table covers the field extremes, dropped payload, abandoned frames
// and zero length. Random well-formed frames with some truncated and some
// overrun follow. Both sides idle at random; the receiver holds off once to
// fill the block, and the sender once drains the block completely.
module binary_command_frame_builder_top_test;
	import bcfb_pkg::*;

	localparam int TARGET_ITEMS = 480;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 20;
	localparam int HOLD_CYCLES  = 120;
	localparam int N_DIRECTED   = 16;

	// One stimulus row: the item, plus wire bytes typed in where obvious
	typedef struct packed {
		bcfb_in_t    item;
		logic        typed;
		logic [3:0]  n_bytes;
		logic [63:0] bytes;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	bcfb_in_t  cmd_item = '0;
	logic      frame_valid;
	logic      frame_ready = 1'b0;
	bcfb_out_t frame_item;

	// Predictor state
	logic [7:0]  fl_sum_a;
	logic [7:0]  fl_sum_b;
	logic [15:0] payload_left;
	logic        frame_open;

	bcfb_out_t step_bytes[$];
	bcfb_out_t wire_bytes_due[$];
	stim_row_t dir_tab[N_DIRECTED];

	int  n_fail = 0;
	int  n_results = 0;
	int  productive = 0;
	int  quiet_cycles = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  steady = 1'b0;

	binary_command_frame_builder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd_item    (cmd_item),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_item  (frame_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_fail(input string msg);
		n_fail++;
		if (n_fail <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	// Predictor: one wire byte, optionally folded into the Fletcher sums
	function automatic void emit_byte(input logic [7:0] b, input logic fe);
		bcfb_out_t o;
		o.out_byte  = b;
		o.frame_end = fe;
		o.run_last  = 1'b0;
		step_bytes.push_back(o);
	endfunction

	function automatic void emit_summed(input logic [7:0] b);
		fl_sum_a = fl_sum_a + b;
		fl_sum_b = fl_sum_b + fl_sum_a;
		emit_byte(b, 1'b0);
	endfunction

	function automatic void emit_checksum();
		emit_byte(fl_sum_a, 1'b0);
		emit_byte(fl_sum_b, 1'b1);
		frame_open   = 1'b0;
		payload_left = '0;
	endfunction

	// Work out the wire bytes that one accepted item causes
	function automatic int predict_wire_bytes(input bcfb_in_t it);
		step_bytes.delete();
		if (it.mode == MODE_START) begin
			fl_sum_a = '0;
			fl_sum_b = '0;
			emit_byte(SYNC_FIRST, 1'b0);
			emit_byte(SYNC_SECOND, 1'b0);
			emit_summed(it.group_id);
			emit_summed(it.sub_id);
			emit_summed(it.payload_length[7:0]);
			emit_summed(it.payload_length[15:8]);
			if (it.payload_length == 16'd0) begin
				emit_checksum();
			end else begin
				payload_left = it.payload_length;
				frame_open   = 1'b1;
			end
		end else begin
			if (!frame_open || payload_left == 16'd0) begin
				frame_open = 1'b0;
				return 0;
			end
			emit_summed(it.payload_byte);
			payload_left = payload_left - 16'd1;
			if (payload_left == 16'd0) begin
				emit_checksum();
			end
		end
		step_bytes[step_bytes.size() - 1].run_last = 1'b1;
		return step_bytes.size();
	endfunction

	// Row builders; fields the mode ignores get random values
	function automatic stim_row_t start_row(input logic [7:0] g, input logic [7:0] s,
			input logic [15:0] len);
		stim_row_t r;
		r = '0;
		r.item.mode           = MODE_START;
		r.item.group_id       = g;
		r.item.sub_id         = s;
		r.item.payload_length = len;
		r.item.payload_byte   = 8'($urandom);
		return r;
	endfunction

	function automatic stim_row_t pay_row(input logic [7:0] b);
		stim_row_t r;
		r = '0;
		r.item.mode           = MODE_PAYLOAD;
		r.item.group_id       = 8'($urandom);
		r.item.sub_id         = 8'($urandom);
		r.item.payload_length = 16'($urandom);
		r.item.payload_byte   = b;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input stim_row_t r, input int n,
			input logic [63:0] bytes);
		stim_row_t t;
		t         = r;
		t.typed   = 1'b1;
		t.n_bytes = 4'(n);
		t.bytes   = bytes;
		return t;
	endfunction

	// Offer one item, wait for acceptance, then queue its wire bytes
	task automatic send_row(input stim_row_t row);
		int n;
		bcfb_out_t o;
		while (!steady && $urandom_range(0, 99) < 29) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= row.item;
		do @(posedge clk); while (!cmd_ready);
		n = predict_wire_bytes(row.item);
		if (n > 0) begin
			productive++;
		end
		if (row.typed) begin
			for (int k = 0; k < row.n_bytes; k++) begin
				o.out_byte  = row.bytes[63 - 8 * k -: 8];
				o.run_last  = (k == row.n_bytes - 1);
				o.frame_end = o.run_last && (row.n_bytes == 8 || row.n_bytes == 3);
				wire_bytes_due.push_back(o);
			end
		end else begin
			foreach (step_bytes[k]) wire_bytes_due.push_back(step_bytes[k]);
		end
	endtask

	// Directed table: extremes, dropped payload, abandon, zero length
	task automatic load_directed();
		dir_tab[0]  = typed_row(pay_row(8'hA5), 0, '0);
		dir_tab[1]  = typed_row(start_row(8'h00, 8'h00, 16'h0000), 8,
			64'hF1D9_0000_0000_0000);
		dir_tab[2]  = typed_row(start_row(8'hFF, 8'hFF, 16'hFFFF), 6,
			64'hF1D9_FFFF_FFFF_0000);
		dir_tab[3]  = pay_row(8'h00);
		dir_tab[4]  = pay_row(8'hFF);
		dir_tab[5]  = start_row(8'h12, 8'h34, 16'h0001);
		dir_tab[6]  = pay_row(8'h80);
		dir_tab[7]  = typed_row(pay_row(8'h7F), 0, '0);
		dir_tab[8]  = start_row(8'hFF, 8'h00, 16'h0000);
		dir_tab[9]  = start_row(8'hA5, 8'h5A, 16'h0002);
		dir_tab[10] = pay_row(8'h55);
		dir_tab[11] = pay_row(8'hAA);
		dir_tab[12] = start_row(8'h01, 8'h80, 16'h0100);
		dir_tab[13] = start_row(8'hC3, 8'h3C, 16'h0002);
		dir_tab[14] = pay_row(8'hFF);
		dir_tab[15] = pay_row(8'hFF);
	endtask

	// Pick a frame length: mostly short, some medium, a few full-range
	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 16'd0;
		if (r < 75) return 16'($urandom_range(1, 6));
		if (r < 92) return 16'($urandom_range(7, 40));
		return 16'($urandom);
	endfunction

	// Result side: check each accepted byte, then pick next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_valid && frame_ready) begin
				n_results++;
				if (wire_bytes_due.size() == 0) begin
					note_fail($sformatf("unexpected byte %02h end=%b last=%b",
						frame_item.out_byte, frame_item.frame_end, frame_item.run_last));
				end else begin
					if (frame_item.out_byte !== wire_bytes_due[0].out_byte)
						note_fail($sformatf("out_byte exp %02h got %02h",
							wire_bytes_due[0].out_byte, frame_item.out_byte));
					if (frame_item.frame_end !== wire_bytes_due[0].frame_end)
						note_fail($sformatf("frame_end exp %b got %b (byte %02h)",
							wire_bytes_due[0].frame_end, frame_item.frame_end,
							wire_bytes_due[0].out_byte));
					if (frame_item.run_last !== wire_bytes_due[0].run_last)
						note_fail($sformatf("run_last exp %b got %b (byte %02h)",
							wire_bytes_due[0].run_last, frame_item.run_last,
							wire_bytes_due[0].out_byte));
					void'(wire_bytes_due.pop_front());
				end
			end
			// Hold off once for a long stretch so the block backs up
			if (!hold_done && n_results >= 150) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				frame_ready <= 1'b0;
			end else begin
				frame_ready <= steady || ($urandom_range(0, 99) >= 29);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (frame_valid && frame_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("binary_command_frame_builder_top_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] len;
		int n_pay;
		int p;
		bit paused;
		paused = 1'b0;
		fl_sum_a     = '0;
		fl_sum_b     = '0;
		payload_left = '0;
		frame_open   = 1'b0;
		load_directed();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) send_row(dir_tab[i]);

		// Random frames: mostly complete, some truncated or overrun
		while (productive < TARGET_ITEMS) begin
			steady = (productive >= 150 && productive < 260);
			if (!paused && productive >= 300) begin
				paused = 1'b1;
				cmd_valid <= 1'b0;
				do @(posedge clk); while (wire_bytes_due.size() != 0);
			end
			if ($urandom_range(0, 99) < 6) begin
				send_row(pay_row(8'($urandom)));
			end else begin
				len = pick_length();
				p = $urandom_range(0, 99);
				if (len > 16'd64)
					n_pay = $urandom_range(0, 8);
				else if (p < 12 && len != 16'd0)
					n_pay = $urandom_range(0, len - 1);
				else if (p < 22)
					n_pay = len + $urandom_range(1, 3);
				else
					n_pay = len;
				send_row(start_row(8'($urandom), 8'($urandom), len));
				for (int i = 0; i < n_pay; i++) send_row(pay_row(8'($urandom)));
			end
		end
		steady = 1'b0;
		cmd_valid <= 1'b0;

		// Drain, then give stray bytes a chance to show up
		while (wire_bytes_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (wire_bytes_due.size() != 0)
			note_fail($sformatf("%0d bytes never arrived", wire_bytes_due.size()));

		if (n_fail == 0) begin
			$display("binary_command_frame_builder_top_test OK");
		end else begin
			$display("binary_command_frame_builder_top_test NOT OK");
		end
		$finish;
	end

endmodule
